>>> src/efcc_pkg.sv
// ----------------------------------------------------------------------------
// Encoder frame CRC checker package
// Shared types, constants and the CRC-6 helper for the frame checker.
// ----------------------------------------------------------------------------
package efcc_pkg;

    // Sensor slots and field widths.
    localparam int SENSOR_COUNT = 4;
    localparam int SLOT_W       = 2;
    localparam int MASK_W       = 4;
    localparam int FRAME_W      = 24;
    localparam int ANGLE_W      = 14;
    localparam int STATUS_W     = 4;
    localparam int CRC_W        = 6;
    localparam int CRC_DATA_W   = ANGLE_W + STATUS_W;

    // Frame layout: angle on top, then status, then the CRC.
    localparam int ANGLE_LSB  = CRC_W + STATUS_W;
    localparam int STATUS_LSB = CRC_W;

    // Status bits that flag a weak or a strong magnetic field.
    localparam int ST_WEAK_POS   = 2;
    localparam int ST_STRONG_POS = 3;

    // CRC-6, polynomial x^6 + x + 1, low terms only.
    localparam logic [CRC_W-1:0] CRC_POLY_LOW = 6'h03;

    typedef logic [CRC_W-1:0]                  t_crc;
    typedef logic [CRC_DATA_W-1:0][CRC_W-1:0]  t_crc_cols;
    typedef logic [SLOT_W-1:0]                 t_slot;
    typedef logic [ANGLE_W-1:0]                t_angle;

    // Classification of one frame.
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_ABSENT    = 2'd0;
    localparam t_kind KIND_LINK_FAIL = 2'd1;
    localparam t_kind KIND_CRC_BAD   = 2'd2;
    localparam t_kind KIND_GOOD      = 2'd3;

    // Command passed from the front end to the back end.
    typedef struct packed {
        t_slot  slot;
        t_kind  kind;
        t_angle angle;
        logic   mag;
    } t_cmd;

    // One result item.
    typedef struct packed {
        t_angle angle;
        logic   err;
        logic   crc_good;
        logic   mag;
        logic   absent;
    } t_result;

    // CRC of a data word that has only bit k set, shifted in MSB first.
    function automatic t_crc crc6_col(input int k);
        t_crc c;
        logic top;
        logic din;
        c = '0;
        for (int j = CRC_DATA_W - 1; j >= 0; j--) begin
            din = (j == k);
            top = c[CRC_W-1];
            c   = {c[CRC_W-2:0], 1'b0};
            if (din ^ top) begin
                c = c ^ CRC_POLY_LOW;
            end
        end
        return c;
    endfunction

    function automatic t_crc_cols crc6_cols_build();
        t_crc_cols cols;
        for (int k = 0; k < CRC_DATA_W; k++) begin
            cols[k] = crc6_col(k);
        end
        return cols;
    endfunction

    // Column table; the CRC is linear, so each data bit adds its column.
    localparam t_crc_cols CRC_COLS = crc6_cols_build();

    // Flat XOR tree over the data bits.
    function automatic t_crc crc6_calc(input logic [CRC_DATA_W-1:0] data);
        t_crc c;
        c = '0;
        for (int k = 0; k < CRC_DATA_W; k++) begin
            if (data[k]) begin
                c = c ^ CRC_COLS[k];
            end
        end
        return c;
    endfunction

endpackage

>>> src/efcc_front.sv
// ----------------------------------------------------------------------------
// Frame classifier
// Holds the present mask, checks the CRC and sorts each frame into a command.
// ----------------------------------------------------------------------------
module efcc_front import efcc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [MASK_W-1:0]  i_cfg_data,
    input  logic               i_accept,
    input  logic [SLOT_W-1:0]  i_sensor_index,
    input  logic [FRAME_W-1:0] i_frame,
    input  logic               i_link_failed,
    output logic               o_cmd_push,
    output t_cmd               o_cmd
);

    logic [MASK_W-1:0] r_present_mask;
    logic              w_present;
    logic              w_crc_ok;
    t_crc              w_crc_calc;

    // Present mask register, written from the configuration channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present_mask <= '0;
        end else if (i_cfg_valid) begin
            r_present_mask <= i_cfg_data;
        end
    end

    // CRC over angle and status.
    assign w_crc_calc = crc6_calc(i_frame[FRAME_W-1:STATUS_LSB]);
    assign w_crc_ok   = (w_crc_calc == i_frame[CRC_W-1:0]);
    assign w_present  = r_present_mask[i_sensor_index];

    // Classification; an absent slot wins over everything else.
    always_comb begin
        o_cmd.slot  = i_sensor_index;
        o_cmd.angle = i_frame[FRAME_W-1:ANGLE_LSB];
        o_cmd.mag   = i_frame[STATUS_LSB + ST_WEAK_POS] |
                      i_frame[STATUS_LSB + ST_STRONG_POS];
        priority if (!w_present) begin
            o_cmd.kind = KIND_ABSENT;
        end else if (i_link_failed) begin
            o_cmd.kind = KIND_LINK_FAIL;
        end else if (!w_crc_ok) begin
            o_cmd.kind = KIND_CRC_BAD;
        end else begin
            o_cmd.kind = KIND_GOOD;
        end
    end

    assign o_cmd_push = i_accept;

endmodule

>>> src/efcc_cmd_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue between the classifier and the slot state update.
// ----------------------------------------------------------------------------
module efcc_cmd_queue import efcc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    // Storage; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Occupancy after this cycle's transfers.
    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

endmodule

>>> src/efcc_back.sv
// ----------------------------------------------------------------------------
// Slot state update
// Applies each command to the held angles and queues the result for the
// consumer. Every command rewrites its slot's error latch completely, so the
// latch after the update is carried by the result's error flag alone.
// ----------------------------------------------------------------------------
module efcc_back import efcc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_empty,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_res
);

    t_angle     r_held  [SENSOR_COUNT];
    t_result    r_res   [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       w_res_full;
    logic       w_take;
    t_result    w_res;
    t_angle     w_held;

    assign w_res_full = (r_count == 2'd2);
    assign w_take     = !i_cmd_empty && !w_res_full;
    assign o_cmd_pop  = w_take;
    assign w_held     = r_held[i_cmd.slot];

    // Result for the command at the head of the queue.
    always_comb begin
        w_res.angle    = w_held;
        w_res.err      = 1'b1;
        w_res.crc_good = 1'b0;
        w_res.mag      = 1'b0;
        w_res.absent   = 1'b0;
        unique case (i_cmd.kind)
            KIND_ABSENT: begin
                w_res.angle  = '0;
                w_res.absent = 1'b1;
            end
            KIND_LINK_FAIL, KIND_CRC_BAD: begin
                w_res.angle = w_held;
            end
            KIND_GOOD: begin
                w_res.angle    = i_cmd.angle;
                w_res.err      = i_cmd.mag;
                w_res.crc_good = 1'b1;
                w_res.mag      = i_cmd.mag;
            end
            default: begin
                w_res.angle = w_held;
            end
        endcase
    end

    // Per-slot state: a good frame stores its angle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SENSOR_COUNT; s++) begin
                r_held[s] <= '0;
            end
        end else if (w_take) begin
            if (i_cmd.kind == KIND_GOOD) begin
                r_held[i_cmd.slot] <= i_cmd.angle;
            end
        end
    end

    // Result queue storage.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_res[r_wr_ptr] <= w_res;
        end
    end

    // Result queue occupancy after this cycle's transfers.
    always_comb begin
        unique case ({w_take, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    // Result queue pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (w_take) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    assign o_empty = (r_count == 2'd0);
    assign o_res   = r_res[r_rd_ptr];

endmodule

>>> src/encoder_frame_crc_checker.sv
// ----------------------------------------------------------------------------
// Encoder frame CRC checker
// Checks the CRC-6 of 24-bit angle encoder frames and keeps the last good
// angle and an error latch for each sensor slot.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  frames    push / full               i_sensor_index, i_frame, i_link_failed
//  results   empty / pop               o_angle_ticks, o_error_flag, o_crc_good,
//                                      o_magnet_fault, o_sensor_absent
//  config    i_cfg_valid / o_cfg_ready i_cfg_data (present mask)
//
// One frame is taken per cycle while full is low. A frame passes the command
// queue and then the result queue before its result is on the output ports.
// full rises when the two-entry command queue is full; the state update
// stalls while the two-entry result queue is full.
// Reset clears both queues, the present mask and the held angles; each
// frame rewrites its slot's error latch, which the error flag reports.
// The configuration channel is always ready.
// ----------------------------------------------------------------------------
module encoder_frame_crc_checker import efcc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [MASK_W-1:0]  i_cfg_data,
    input  logic               push,
    output logic               full,
    input  logic [SLOT_W-1:0]  i_sensor_index,
    input  logic [FRAME_W-1:0] i_frame,
    input  logic               i_link_failed,
    output logic               empty,
    input  logic               pop,
    output logic [ANGLE_W-1:0] o_angle_ticks,
    output logic               o_error_flag,
    output logic               o_crc_good,
    output logic               o_magnet_fault,
    output logic               o_sensor_absent
);

    logic    w_accept;
    logic    w_cmd_push;
    t_cmd    w_cmd_in;
    logic    w_cmd_empty;
    logic    w_cmd_pop;
    t_cmd    w_cmd_out;
    t_result w_res;
    logic    w_cfg_write;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;
    assign w_accept    = push && !full;

    // Front end: classification and CRC check.
    efcc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (w_cfg_write),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (w_accept),
        .i_sensor_index (i_sensor_index),
        .i_frame        (i_frame),
        .i_link_failed  (i_link_failed),
        .o_cmd_push     (w_cmd_push),
        .o_cmd          (w_cmd_in)
    );

    // Queue between front and back.
    efcc_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_cmd   (w_cmd_in),
        .o_full  (full),
        .i_pop   (w_cmd_pop),
        .o_empty (w_cmd_empty),
        .o_cmd   (w_cmd_out)
    );

    // Back end: slot state and result queue.
    efcc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (w_cmd_empty),
        .i_cmd       (w_cmd_out),
        .o_cmd_pop   (w_cmd_pop),
        .i_pop       (pop && !empty),
        .o_empty     (empty),
        .o_res       (w_res)
    );

    assign o_angle_ticks   = w_res.angle;
    assign o_error_flag    = w_res.err;
    assign o_crc_good      = w_res.crc_good;
    assign o_magnet_fault  = w_res.mag;
    assign o_sensor_absent = w_res.absent;

    // The back end never takes a command from an empty queue.
    a_cmd_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> !w_cmd_empty)
        else $error("command taken from an empty queue");

    // A frame transfer into an idle block has its result waiting once it has passed the command and result queues.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && empty && w_cmd_empty) |-> ##2 !empty)
        else $error("result missing two cycles after frame transfer");

    // An absent slot reports angle zero with the error set.
    a_absent_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_sensor_absent) |->
            (o_angle_ticks == '0) && o_error_flag && !o_crc_good && !o_magnet_fault)
        else $error("absent slot result is inconsistent");

    // A good frame sets the error flag to the magnet fault alone.
    a_good_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_crc_good) |-> (o_error_flag == o_magnet_fault) && !o_sensor_absent)
        else $error("good frame result is inconsistent");

endmodule

>>> dv/tb_encoder_frame_crc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder frame CRC checker testbench
// Sends encoder frames to every sensor slot under several present masks and
// compares each readout against a slot-by-slot prediction of the CRC check,
// the held angles and the error latches. Both sides idle at random, and one
// long receiver hold-off fills the block so that it stalls its input.
// ----------------------------------------------------------------------------
module tb_encoder_frame_crc_checker;
    import efcc_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int MASK_ALL   = (1 << MASK_W) - 1;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [MASK_W-1:0]  i_cfg_data = '0;
    logic               push = 1'b0;
    logic               full;
    logic [SLOT_W-1:0]  i_sensor_index = '0;
    logic [FRAME_W-1:0] i_frame = '0;
    logic               i_link_failed = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic [ANGLE_W-1:0] o_angle_ticks;
    logic               o_error_flag;
    logic               o_crc_good;
    logic               o_magnet_fault;
    logic               o_sensor_absent;

    // Predicted slot state and the readouts still owed by the block.
    t_angle             slot_angle [SENSOR_COUNT];
    logic               slot_fault [SENSOR_COUNT];
    logic [MASK_W-1:0]  present_slots;
    t_result            pending_readouts [$];
    t_result            want_readout;

    // Pacing controls shared by the tests and the receiver.
    bit                 tx_steady = 1'b0;
    bit                 rx_steady = 1'b0;
    int                 rx_hold_left = 0;
    int                 rx_gap = 0;
    int                 bad_results = 0;
    int                 idle_cycles = 0;

    encoder_frame_crc_checker u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .push            (push),
        .full            (full),
        .i_sensor_index  (i_sensor_index),
        .i_frame         (i_frame),
        .i_link_failed   (i_link_failed),
        .empty           (empty),
        .pop             (pop),
        .o_angle_ticks   (o_angle_ticks),
        .o_error_flag    (o_error_flag),
        .o_crc_good      (o_crc_good),
        .o_magnet_fault  (o_magnet_fault),
        .o_sensor_absent (o_sensor_absent)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // CRC-6, x^6 + x + 1, zero start, shifted in MSB first.
    function automatic logic [CRC_W-1:0] crc6_msb_first(input logic [CRC_DATA_W-1:0] bits);
        logic [CRC_W-1:0] c;
        logic             fb;
        c = '0;
        for (int k = CRC_DATA_W - 1; k >= 0; k--) begin
            fb = bits[k] ^ c[CRC_W-1];
            c  = {c[CRC_W-2:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY_LOW;
            end
        end
        return c;
    endfunction

    function automatic logic [FRAME_W-1:0] good_frame(input t_angle a,
                                                      input logic [STATUS_W-1:0] st);
        return {a, st, crc6_msb_first({a, st})};
    endfunction

    // Expected readout for one frame; updates the predicted slot state.
    function automatic t_result predict_readout(input t_slot slot,
                                                input logic [FRAME_W-1:0] frame,
                                                input logic link_bad);
        t_result r;
        logic    mag;
        r = '0;
        if (!present_slots[slot]) begin
            r.absent         = 1'b1;
            r.err            = 1'b1;
            slot_fault[slot] = 1'b1;
        end else if (link_bad ||
                     crc6_msb_first(frame[FRAME_W-1:STATUS_LSB]) != frame[CRC_W-1:0]) begin
            // Failed transfer or CRC mismatch: report the held angle.
            slot_fault[slot] = 1'b1;
            r.angle          = slot_angle[slot];
            r.err            = 1'b1;
        end else begin
            mag = frame[STATUS_LSB + ST_WEAK_POS] | frame[STATUS_LSB + ST_STRONG_POS];
            slot_fault[slot] = mag;
            slot_angle[slot] = frame[FRAME_W-1:ANGLE_LSB];
            r.angle          = frame[FRAME_W-1:ANGLE_LSB];
            r.err            = mag;
            r.crc_good       = 1'b1;
            r.mag            = mag;
        end
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 80);
    endfunction

    // Offer one frame and wait for its transfer.
    task automatic send_frame(input t_slot slot, input logic [FRAME_W-1:0] frame,
                              input logic link_bad);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_sensor_index <= slot;
        i_frame        <= frame;
        i_link_failed  <= link_bad;
        push           <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        pending_readouts.push_back(predict_readout(slot, frame, link_bad));
    endtask

    // Stop offering and wait until every readout has come back.
    task automatic drain_block();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_readouts.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_present_mask(input logic [MASK_W-1:0] mask);
        drain_block();
        @(negedge i_clk);
        i_cfg_data  <= mask;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        present_slots = mask;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random frame: mostly good, some corrupted, some failed transfers.
    task automatic send_random_frame();
        int                 r;
        logic [FRAME_W-1:0] f;
        r = $urandom_range(0, 99);
        f = good_frame(t_angle'($urandom_range(0, (1 << ANGLE_W) - 1)),
                       STATUS_W'($urandom_range(0, (1 << STATUS_W) - 1)));
        if (r < 60) begin
            send_frame(t_slot'($urandom_range(0, 3)), f, 1'b0);
        end else if (r < 75) begin
            f[CRC_W-1:0] = f[CRC_W-1:0] ^ CRC_W'($urandom_range(1, (1 << CRC_W) - 1));
            send_frame(t_slot'($urandom_range(0, 3)), f, 1'b0);
        end else if (r < 88) begin
            if ($urandom_range(0, 1) == 1) begin
                f = FRAME_W'($urandom);
            end
            send_frame(t_slot'($urandom_range(0, 3)), f, 1'b1);
        end else begin
            send_frame(t_slot'($urandom_range(0, 3)), FRAME_W'($urandom),
                       1'($urandom_range(0, 1)));
        end
    endtask

    // Absent slots: the reset mask, then a mask with two slots present.
    task automatic test_absent_slots();
        for (int s = 0; s < SENSOR_COUNT; s++) begin
            send_frame(t_slot'(s), good_frame(t_angle'(s * 100), '0), 1'b0);
        end
        write_present_mask('0);
        send_frame(t_slot'(3), FRAME_W'($urandom), 1'b1);
        write_present_mask(MASK_W'(4'b0101));
        for (int s = 0; s < SENSOR_COUNT; s++) begin
            send_frame(t_slot'(s), good_frame(t_angle'(s * 1000 + 7), 4'b0001), 1'b0);
        end
    endtask

    // Field extremes, magnet status bits, CRC errors and link failures.
    task automatic test_frame_cases();
        logic [FRAME_W-1:0] f;
        write_present_mask(MASK_W'(MASK_ALL));
        send_frame(t_slot'(0), '0, 1'b0);
        send_frame(t_slot'(1), good_frame('1, '0), 1'b0);
        send_frame(t_slot'(2), good_frame(t_angle'(14'h1555), 4'b0100), 1'b0);
        send_frame(t_slot'(3), good_frame(t_angle'(14'h2AAA), 4'b1000), 1'b0);
        send_frame(t_slot'(0), good_frame(t_angle'(14'h0123), 4'b0011), 1'b0);
        send_frame(t_slot'(0), good_frame(t_angle'(14'h3210), 4'b1111), 1'b0);
        // A good frame with clean status clears the latch again.
        send_frame(t_slot'(0), good_frame(t_angle'(14'h0001), 4'b0000), 1'b0);
        f = good_frame(t_angle'(14'h0F0F), 4'b0000);
        send_frame(t_slot'(1), {f[FRAME_W-1:CRC_W], f[CRC_W-1:0] ^ 6'h3F}, 1'b0);
        send_frame(t_slot'(1), {f[FRAME_W-1:CRC_W], f[CRC_W-1:0] ^ 6'h01}, 1'b0);
        send_frame(t_slot'(1), f, 1'b0);
        send_frame(t_slot'(2), good_frame(t_angle'(14'h0777), 4'b0000), 1'b1);
        send_frame(t_slot'(2), good_frame(t_angle'(14'h0777), 4'b0000), 1'b0);
        send_frame(t_slot'(3), {f[FRAME_W-1:CRC_W], ~f[CRC_W-1:0]}, 1'b1);
        send_frame(t_slot'(3), '1, 1'b0);
        send_frame(t_slot'(3), '1, 1'b1);
    endtask

    // Receiver holds off while frames keep coming, so the input stalls.
    task automatic test_output_stall();
        drain_block();
        tx_steady    = 1'b1;
        rx_hold_left = 150;
        for (int n = 0; n < 40; n++) begin
            send_random_frame();
        end
        tx_steady = 1'b0;
    endtask

    // Random frames in chunks, each under its own mask and pacing.
    task automatic test_random_frames();
        logic [MASK_W-1:0] masks [5];
        masks[0] = MASK_W'(MASK_ALL);
        masks[1] = MASK_W'($urandom_range(1, MASK_ALL - 1));
        masks[2] = '0;
        masks[3] = MASK_W'($urandom_range(0, MASK_ALL));
        masks[4] = MASK_W'(MASK_ALL);
        for (int chunk = 0; chunk < 5; chunk++) begin
            write_present_mask(masks[chunk]);
            tx_steady = (chunk == 1) || (chunk == 4);
            rx_steady = (chunk == 3) || (chunk == 4);
            for (int n = 0; n < ((chunk == 2) ? 60 : 240); n++) begin
                send_random_frame();
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Receiver: random idle stretches plus the long hold-off on request.
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                pop <= 1'b0;
                rx_hold_left = rx_hold_left - 1;
            end else if (rx_gap > 0) begin
                pop <= 1'b0;
                rx_gap = rx_gap - 1;
            end else begin
                pop <= 1'b1;
                if (!rx_steady && $urandom_range(0, 2) == 0) begin
                    rx_gap = pick_gap();
                end
            end
        end
    end

    // Compare each result transfer with the oldest predicted readout.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_readouts.size() == 0) begin
                bad_results++;
                if (bad_results <= 10) begin
                    $display("ERROR: readout with none expected: angle %0d err %0b",
                             o_angle_ticks, o_error_flag);
                end
            end else begin
                want_readout = pending_readouts.pop_front();
                if (o_angle_ticks !== want_readout.angle ||
                    o_error_flag !== want_readout.err ||
                    o_crc_good !== want_readout.crc_good ||
                    o_magnet_fault !== want_readout.mag ||
                    o_sensor_absent !== want_readout.absent) begin
                    bad_results++;
                    if (bad_results <= 10) begin
                        $display({"ERROR: readout mismatch: expected angle %0d err %0b ",
                                  "crc %0b mag %0b absent %0b, got angle %0d err %0b ",
                                  "crc %0b mag %0b absent %0b"},
                                 want_readout.angle, want_readout.err,
                                 want_readout.crc_good, want_readout.mag,
                                 want_readout.absent, o_angle_ticks, o_error_flag,
                                 o_crc_good, o_magnet_fault, o_sensor_absent);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any transfer.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_encoder_frame_crc_checker NOT OK");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        for (int s = 0; s < SENSOR_COUNT; s++) begin
            slot_angle[s] = '0;
            slot_fault[s] = 1'b0;
        end
        present_slots = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_absent_slots();
        test_frame_cases();
        test_output_stall();
        test_random_frames();

        drain_block();
        repeat (8) @(posedge i_clk);
        if (bad_results == 0 && pending_readouts.size() == 0) begin
            $display("tb_encoder_frame_crc_checker OK");
        end else begin
            $display("tb_encoder_frame_crc_checker NOT OK");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/efcc_pkg.sv
src/efcc_front.sv
src/efcc_cmd_queue.sv
src/efcc_back.sv
src/encoder_frame_crc_checker.sv
dv/tb_encoder_frame_crc_checker.sv
